// ===== src/swsd_pkg.sv =====
`default_nettype none

package swsd_pkg;

  // Field and register widths
  localparam int TICK_W    = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int TEMP_W    = 12;
  localparam int HUM_W     = 11;
  localparam int CNT_W     = 7;

  // Frame layout
  localparam int FRAME_BITS     = 40;
  localparam int PREAMBLE_EDGES = 2;
  localparam int BYTE_W         = 8;
  localparam int RAW_W          = 16;
  localparam int MAG_W          = 15;

  localparam logic [CNT_W-1:0] CNT_MAX      = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_PREAMBLE = CNT_W'(PREAMBLE_EDGES);
  localparam logic [CNT_W-1:0] CNT_FRAME_END = CNT_W'(FRAME_BITS + PREAMBLE_EDGES);

  // Range limits in tenths
  localparam logic [RAW_W-1:0] HUM_MAX_TENTHS      = RAW_W'(1100);
  localparam logic [MAG_W-1:0] TEMP_POS_MAX_TENTHS = MAG_W'(1350);
  localparam logic [MAG_W-1:0] TEMP_NEG_MAX_TENTHS = MAG_W'(500);

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_MAX  = 2'd2;

  localparam logic [CFG_W-1:0] ZERO_MIN_RESET = CFG_W'(60);
  localparam logic [CFG_W-1:0] ZERO_MAX_RESET = CFG_W'(100);
  localparam logic [CFG_W-1:0] ONE_MAX_RESET  = CFG_W'(150);

  // Input command codes and line level
  localparam logic CMD_EDGE   = 1'b0;
  localparam logic CMD_ARM    = 1'b1;
  localparam logic LEVEL_HIGH = 1'b1;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_BAD_SUM  = 2'd1,
    ST_BAD_DATA = 2'd2
  } status_e;

  typedef struct packed {
    logic [CFG_W-1:0] zero_min;
    logic [CFG_W-1:0] zero_max;
    logic [CFG_W-1:0] one_max;
  } cfg_t;

  typedef struct packed {
    logic              command;
    logic              level;
    logic [TICK_W-1:0] tick;
  } edge_beat_t;

  typedef struct packed {
    status_e                  status;
    logic signed [TEMP_W-1:0] temp;
    logic [HUM_W-1:0]         hum;
  } check_t;

  typedef struct packed {
    logic                     valid;
    status_e                  status;
    logic signed [TEMP_W-1:0] temp;
    logic [HUM_W-1:0]         hum;
  } result_t;

endpackage

`default_nettype wire

// ===== src/swsd_in_reg.sv =====
`default_nettype none

module swsd_in_reg import swsd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire edge_beat_t in_beat_i,
  output logic            in_stall_o,
  input  wire logic       advance_i,
  output logic            beat_valid_o,
  output edge_beat_t      beat_o
);

  logic       valid_q, valid_d;
  edge_beat_t beat_q;
  logic       load;

  // Take a beat when the slot is empty or drains this cycle
  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold payload until the next load
  always_ff @(posedge clk_i) begin
    if (load) begin
      beat_q <= in_beat_i;
    end
  end

  assign beat_valid_o = valid_q;
  assign beat_o       = beat_q;

endmodule

`default_nettype wire

// ===== src/swsd_frame_check.sv =====
`default_nettype none

module swsd_frame_check import swsd_pkg::*; (
  input  wire logic [FRAME_BITS-1:0] frame_i,
  output check_t                     check_o
);

  logic [BYTE_W-1:0] b0, b1, b2, b3, b4;
  logic [BYTE_W-1:0] sum;
  logic [RAW_W-1:0]  hum_raw;
  logic [MAG_W-1:0]  mag;
  logic              neg;
  logic              range_ok;
  logic [RAW_W-1:0]  temp_wide;

  // Split the word, last received byte lowest
  assign b0 = frame_i[0*BYTE_W +: BYTE_W];
  assign b1 = frame_i[1*BYTE_W +: BYTE_W];
  assign b2 = frame_i[2*BYTE_W +: BYTE_W];
  assign b3 = frame_i[3*BYTE_W +: BYTE_W];
  assign b4 = frame_i[4*BYTE_W +: BYTE_W];

  assign sum     = b1 + b2 + b3 + b4;
  assign hum_raw = {b4, b3};
  assign mag     = {b2[BYTE_W-2:0], b1};
  assign neg     = b2[BYTE_W-1];

  // Range check, negative side has its own limit
  always_comb begin
    range_ok = (hum_raw <= HUM_MAX_TENTHS);
    if (neg) begin
      range_ok = range_ok && (mag <= TEMP_NEG_MAX_TENTHS);
    end else begin
      range_ok = range_ok && (mag <= TEMP_POS_MAX_TENTHS);
    end
  end

  // Negate the magnitude for a set sign bit; negative zero gives zero
  assign temp_wide = neg ? (RAW_W'(0) - {1'b0, mag}) : {1'b0, mag};

  always_comb begin
    check_o.temp = temp_wide[TEMP_W-1:0];
    check_o.hum  = hum_raw[HUM_W-1:0];
    if (sum != b0) begin
      check_o.status = ST_BAD_SUM;
    end else if (!range_ok) begin
      check_o.status = ST_BAD_DATA;
    end else begin
      check_o.status = ST_GOOD;
    end
  end

endmodule

`default_nettype wire

// ===== src/swsd_bit_core.sv =====
`default_nettype none

module swsd_bit_core import swsd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cfg_t       cfg_i,
  input  wire logic       fire_i,
  input  wire edge_beat_t beat_i,
  output result_t         result_o
);

  logic [TICK_W-1:0]        prev_q, prev_d;
  logic                     awaiting_q, awaiting_d;
  logic                     receiving_q, receiving_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [FRAME_BITS-1:0]    shift_q, shift_d;
  logic signed [TEMP_W-1:0] held_temp_q, held_temp_d;
  logic [HUM_W-1:0]         held_hum_q, held_hum_d;

  logic [TICK_W-1:0]     delta;
  logic [TICK_W-1:0]     zmin_x, zmax_x, omax_x;
  logic                  is_zero, is_one;
  logic [CNT_W-1:0]      cnt_inc;
  logic [FRAME_BITS-1:0] frame_next;
  check_t                check;

  // Interval since the last rising edge, wraps with the timestamp
  assign delta  = beat_i.tick - prev_q;
  assign zmin_x = {{(TICK_W-CFG_W){1'b0}}, cfg_i.zero_min};
  assign zmax_x = {{(TICK_W-CFG_W){1'b0}}, cfg_i.zero_max};
  assign omax_x = {{(TICK_W-CFG_W){1'b0}}, cfg_i.one_max};

  assign is_zero = (delta >= zmin_x) && (delta <= zmax_x);
  assign is_one  = !is_zero && (delta > zmax_x) && (delta <= omax_x);

  assign cnt_inc    = (cnt_q < CNT_MAX) ? cnt_q + CNT_W'(1) : cnt_q;
  assign frame_next = {shift_q[FRAME_BITS-2:0], is_one};

  swsd_frame_check u_check (
    .frame_i (frame_next),
    .check_o (check)
  );

  // Sequence one beat through the frame state
  always_comb begin
    prev_d      = prev_q;
    awaiting_d  = awaiting_q;
    receiving_d = receiving_q;
    cnt_d       = cnt_q;
    shift_d     = shift_q;
    held_temp_d = held_temp_q;
    held_hum_d  = held_hum_q;
    result_o.valid  = 1'b0;
    result_o.status = check.status;

    if (fire_i) begin
      if (beat_i.command == CMD_ARM) begin
        awaiting_d = 1'b1;
      end else if (beat_i.level == LEVEL_HIGH) begin
        prev_d = beat_i.tick;
        if (awaiting_q) begin
          awaiting_d  = 1'b0;
          receiving_d = 1'b1;
          cnt_d       = '0;
          shift_d     = '0;
        end else if (receiving_q) begin
          cnt_d = cnt_inc;
          if (cnt_inc > CNT_PREAMBLE) begin
            if (is_zero || is_one) begin
              shift_d = frame_next;
              if (cnt_inc == CNT_FRAME_END) begin
                receiving_d    = 1'b0;
                result_o.valid = 1'b1;
                if (check.status == ST_GOOD) begin
                  held_temp_d = check.temp;
                  held_hum_d  = check.hum;
                end
              end
            end else begin
              // drop the frame on an out-of-window interval
              receiving_d = 1'b0;
            end
          end
        end
      end
    end

    result_o.temp = held_temp_d;
    result_o.hum  = held_hum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      awaiting_q  <= 1'b1;
      receiving_q <= 1'b0;
      cnt_q       <= '0;
      shift_q     <= '0;
      held_temp_q <= '0;
      held_hum_q  <= '0;
    end else begin
      prev_q      <= prev_d;
      awaiting_q  <= awaiting_d;
      receiving_q <= receiving_d;
      cnt_q       <= cnt_d;
      shift_q     <= shift_d;
      held_temp_q <= held_temp_d;
      held_hum_q  <= held_hum_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/single_wire_sensor_frame_decoder.sv =====
// Pulse-width frame decoder for a single-wire humidity/temperature sensor.
// Input channel (in_valid_i / in_stall_o): one beat per line event, carrying
// a command (edge or arm), the line level and a microsecond timestamp.
// Output channel (out_valid_o / out_stall_i): one status beat per completed
// frame, with the last good temperature and humidity in tenths.
// Config channel (cfg_valid_i / cfg_ready_o): always ready; writes the zero
// and one interval windows. Write only while the block is idle.
// A beat is registered in the input register on accept; while the output
// slot is free it advances through the core and its result, if any, is
// registered in the output register. Throughput is one beat per cycle
// while the output does not stall, set by the single subtract/compare/shift
// path from the input register to the state and result registers.
// A stalled output holds its beat; one further input beat is taken into
// the input register and then in_stall_o rises until the output drains.
// Reset clears all frame state and held values, loads the default windows
// and leaves the block armed for a start edge.
`default_nettype none

module single_wire_sensor_frame_decoder import swsd_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 in_command_i,
  input  wire logic                 in_level_i,
  input  wire logic [TICK_W-1:0]    in_tick_us_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [1:0]                out_status_o,
  output logic signed [TEMP_W-1:0]  out_temperature_tenths_o,
  output logic [HUM_W-1:0]          out_humidity_tenths_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  cfg_t       cfg_q, cfg_d;
  edge_beat_t in_beat;
  edge_beat_t beat;
  logic       beat_valid;
  logic       out_free;
  logic       fire;
  result_t    result;

  logic                     out_valid_q, out_valid_d;
  status_e                  out_status_q;
  logic signed [TEMP_W-1:0] out_temp_q;
  logic [HUM_W-1:0]         out_hum_q;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ZERO_MIN: cfg_d.zero_min = cfg_data_i;
        CFG_ZERO_MAX: cfg_d.zero_max = cfg_data_i;
        CFG_ONE_MAX:  cfg_d.one_max  = cfg_data_i;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zero_min <= ZERO_MIN_RESET;
      cfg_q.zero_max <= ZERO_MAX_RESET;
      cfg_q.one_max  <= ONE_MAX_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Input register
  assign in_beat.command = in_command_i;
  assign in_beat.level   = in_level_i;
  assign in_beat.tick    = in_tick_us_i;

  swsd_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_beat_i    (in_beat),
    .in_stall_o   (in_stall_o),
    .advance_i    (fire),
    .beat_valid_o (beat_valid),
    .beat_o       (beat)
  );

  // Advance the held beat when the output slot can take a result
  assign out_free = !out_valid_q || !out_stall_i;
  assign fire     = beat_valid && out_free;

  swsd_bit_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .fire_i   (fire),
    .beat_i   (beat),
    .result_o (result)
  );

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = result.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && result.valid) begin
      out_status_q <= result.status;
      out_temp_q   <= result.temp;
      out_hum_q    <= result.hum;
    end
  end

  assign out_valid_o              = out_valid_q;
  assign out_status_o             = out_status_q;
  assign out_temperature_tenths_o = out_temp_q;
  assign out_humidity_tenths_o    = out_hum_q;

  // Stall only with a beat waiting in the input register
  a_stall_needs_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> beat_valid)
    else $error("input stalled with an empty input register");

  // A result comes only from a beat that advances
  a_result_on_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result.valid |-> fire)
    else $error("result produced without an advancing beat");

  // Held values delivered with a good status are in range
  a_good_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_status_o == ST_GOOD) |->
      ((out_humidity_tenths_o <= HUM_W'(1100)) &&
       (out_temperature_tenths_o >= -TEMP_W'(500)) &&
       (out_temperature_tenths_o <= TEMP_W'(1350))))
    else $error("good frame delivered out-of-range values");

endmodule

`default_nettype wire
